// ===== rtl/sorted_insert_store_top_defines.svh =====
// Assertion macros shared by the checker of the sorted insert store.
// Needs a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef SORTED_INSERT_STORE_TOP_DEFINES_SVH
`define SORTED_INSERT_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define SIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted insert store check failed");

// next-cycle implication
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted insert store check failed");

`endif

// ===== rtl/sis_pkg.sv =====
// Package of the sorted insert store: sizes, status codes, cell and control types.
// No dependencies.
`default_nettype none

package sis_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DRAINED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DRAIN
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_e;

  typedef struct packed {
    cell_op_e op;
    data_t    value;
  } cell_ctrl_t;

  typedef struct packed {
    data_t value;
    logic  valid;
    logic  ge;
  } cell_link_t;

  typedef struct packed {
    logic  dup;
    logic  full;
    logic  head_valid;
    data_t head_value;
    logic  next_valid;
  } chain_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sis_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the broadcast value,
// takes the left entry or the broadcast value on insert, the right entry on drain. Uses sis_pkg.
`default_nettype none

module sis_cell
  import sis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o,
  output logic       eq_o
);

  data_t value_q, value_d;
  logic  valid_q, valid_d;
  logic  ge;

  assign ge     = valid_q && !(value_q < ctrl_i.value);
  assign eq_o   = valid_q && (value_q == ctrl_i.value);
  assign link_o = '{value: value_q, valid: valid_q, ge: ge};

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if ((valid_q && ge) || (!valid_q && left_i.valid)) begin
          value_d = left_i.ge ? left_i.value : ctrl_i.value;
          valid_d = 1'b1;
        end
      end
      OP_DRAIN: begin
        value_d = right_i.value;
        valid_d = right_i.valid;
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sis_ctrl.sv =====
// Command sequencer of the sorted insert store: decodes beats, drives the chain
// operation and registers the result beat. Uses sis_pkg.
`default_nettype none

module sis_ctrl
  import sis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  data_t       value_i,
  input  chain_stat_t stat_i,
  output cell_ctrl_t  ctrl_o,
  output logic        strobe_o,
  output status_e     status_o,
  output data_t       entry_value_o,
  output logic        last_o
);

  state_e  state_q, state_d;
  logic    strobe_q, strobe_d;
  status_e status_q, status_d;
  data_t   entry_q, entry_d;
  logic    last_q, last_d;

  always_comb begin
    state_d  = state_q;
    ctrl_o   = '{op: OP_HOLD, value: value_i};
    strobe_d = 1'b0;
    status_d = ST_INSERTED;
    entry_d  = value_i;
    last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          strobe_d = 1'b1;
          if (cmd_i == CMD_DRAIN) begin
            if (!stat_i.head_valid) begin
              status_d = ST_EMPTY;
              entry_d  = '0;
            end else begin
              status_d  = ST_DRAINED;
              entry_d   = stat_i.head_value;
              last_d    = !stat_i.next_valid;
              ctrl_o.op = OP_DRAIN;
              if (stat_i.next_valid) begin
                state_d = S_DRAIN;
              end
            end
          end else if (stat_i.dup) begin
            status_d = ST_DUPLICATE;
          end else if (stat_i.full) begin
            status_d = ST_FULL;
          end else begin
            ctrl_o.op = OP_INSERT;
          end
        end
      end
      S_DRAIN: begin
        strobe_d  = 1'b1;
        status_d  = ST_DRAINED;
        entry_d   = stat_i.head_value;
        last_d    = !stat_i.next_valid;
        ctrl_o.op = OP_DRAIN;
        if (!stat_i.next_valid) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign busy          = (state_q == S_DRAIN);
  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign entry_value_o = entry_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_store_top.sv =====
// Top level of the sorted insert store: a row of sis_cell slots and the sis_ctrl sequencer.
// Uses sis_pkg, sis_cell and sis_ctrl.
// Every result beat is registered and appears in the cycle after the command beat or the previous result.
// Throughput: one insert per cycle while not busy; a drain holds busy while all but its first entry leave,
// one entry per cycle as the cell row shifts toward slot 0; the receiver cannot stall.
// Reset clears the slot valid bits and the sequencer; slot contents stay unset until written.
`default_nettype none

module sorted_insert_store_top
  import sis_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic signed [31:0]  value_i,
  output logic                strobe_o,
  output logic [STATUS_W-1:0] status_o,
  output logic signed [31:0]  entry_value_o,
  output logic                last_o
);

  localparam cell_link_t HEAD_TIE = '{value: '0, valid: 1'b1, ge: 1'b0};
  localparam cell_link_t TAIL_TIE = '{value: '0, valid: 1'b0, ge: 1'b0};

  cell_ctrl_t            cell_ctrl;
  cell_link_t            cell_link [CAPACITY];
  logic [CAPACITY-1:0]   cell_eq;
  chain_stat_t           chain_stat;
  status_e               status;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = HEAD_TIE;
    end else begin : g_left
      assign left_link = cell_link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_link = TAIL_TIE;
    end else begin : g_right
      assign right_link = cell_link[i+1];
    end

    sis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (cell_link[i]),
      .eq_o    (cell_eq[i])
    );
  end

  assign chain_stat = '{
    dup:        |cell_eq,
    full:       cell_link[CAPACITY-1].valid,
    head_valid: cell_link[0].valid,
    head_value: cell_link[0].value,
    next_valid: cell_link[1].valid
  };

  sis_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .stat_i        (chain_stat),
    .ctrl_o        (cell_ctrl),
    .strobe_o      (strobe_o),
    .status_o      (status),
    .entry_value_o (entry_value_o),
    .last_o        (last_o)
  );

  assign status_o = status;

endmodule

`default_nettype wire

// ===== rtl/sis_checker.sv =====
// Port-level checks on the sorted insert store, bound to sorted_insert_store_top.
// Uses sis_pkg and sorted_insert_store_top_defines.svh.
`default_nettype none

`include "sorted_insert_store_top_defines.svh"

module sis_checker
  import sis_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                strobe_o,
  input logic [STATUS_W-1:0] status_o,
  input logic                last_o
);

  `SIS_ASSERT_NEXT(a_cmd_gives_beat, start && !busy, strobe_o)
  `SIS_ASSERT_NOW(a_drain_beats_flow, busy, strobe_o)
  `SIS_ASSERT_NOW(a_mid_drain_busy, strobe_o && !last_o, busy && (status_o == ST_DRAINED))
  `SIS_ASSERT_NOW(a_final_beat_frees, strobe_o && last_o, !busy)
  `SIS_ASSERT_NOW(a_single_beat_last, strobe_o && (status_o != ST_DRAINED), last_o)

endmodule

bind sorted_insert_store_top sis_checker u_sis_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .status_o (status_o),
  .last_o   (last_o)
);

`default_nettype wire
